[rtl/sprm_pkg.sv]
package sprm_pkg;

  localparam int unsigned NumW   = 20;
  localparam int unsigned WinW   = 31;
  localparam int unsigned TickW  = 32;
  localparam int unsigned RpmW   = 21;
  localparam int unsigned ToothW = 8;
  localparam int unsigned IdxW   = 2;
  localparam int unsigned CfgW   = 31;
  localparam int unsigned CntW   = $clog2(NumW);

  localparam logic [NumW-1:0]  NumReset = NumW'(60000);
  localparam logic [WinW-1:0]  WinReset = WinW'(1000);
  localparam logic [TickW-1:0] SatTicks = {TickW{1'b1}};
  localparam logic [RpmW-1:0]  RpmNoise = {RpmW{1'b1}};

  localparam logic [IdxW-1:0] RegNumerator = IdxW'(0);
  localparam logic [IdxW-1:0] RegWindow    = IdxW'(1);

  localparam logic KindTick  = 1'b0;
  localparam logic KindEvent = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic in_stall;
    logic out_load;
  } ctrl_t;

endpackage

[rtl/shaft_period_rpm_meter_core.sv]
// An accepted input beat goes through the HOLD state into the output register once
// that register is free; a tooth-zero event while running, with a nonzero tick count,
// first runs the 20-step bit-serial divider. No new beat is taken until that load.
// One input beat may be taken while the output register still waits on stall.
// Synchronous reset: numerator 60000, window 1000, counter saturated, speed 0.
module shaft_period_rpm_meter_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               kind,
  input  logic [sprm_pkg::ToothW-1:0]        tooth_index,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [sprm_pkg::RpmW-1:0]   rpm_value,
  output logic                               running,
  input  logic                               cfg_we,
  input  logic [sprm_pkg::IdxW-1:0]          cfg_index,
  input  logic [sprm_pkg::CfgW-1:0]          cfg_data
);

  sprm_pkg::state_t state, state_next;
  sprm_pkg::ctrl_t  ctrl;

  logic [sprm_pkg::NumW-1:0]  rpm_numerator;
  logic [sprm_pkg::WinW-1:0]  running_window;
  logic [sprm_pkg::TickW-1:0] elapsed_ticks;
  logic [sprm_pkg::RpmW-1:0]  stored_rpm;

  logic [sprm_pkg::NumW-1:0]  quo;
  logic [sprm_pkg::RpmW-1:0]  rem;
  logic [sprm_pkg::WinW-1:0]  divisor;
  logic [sprm_pkg::CntW-1:0]  cnt;

  logic                       accept;
  logic                       is_running;
  logic                       measured;
  logic [sprm_pkg::RpmW-1:0]  trial;
  logic                       q_bit;
  logic [sprm_pkg::RpmW-1:0]  rem_next;

  assign accept     = in_valid && !ctrl.in_stall;
  assign in_stall   = ctrl.in_stall;
  assign is_running = elapsed_ticks < {1'b0, running_window};
  assign measured   = (kind == sprm_pkg::KindEvent) && (tooth_index == '0);

  // restoring divide step: one quotient bit per cycle
  assign trial    = {rem[sprm_pkg::RpmW-2:0], quo[sprm_pkg::NumW-1]};
  assign q_bit    = {{(sprm_pkg::WinW-sprm_pkg::RpmW){1'b0}}, trial} >= divisor;
  assign rem_next = q_bit ? (trial - divisor[sprm_pkg::RpmW-1:0]) : trial;

  always_comb begin
    state_next = state;
    case (state)
      sprm_pkg::ST_IDLE: begin
        if (accept) begin
          if (measured && is_running && (elapsed_ticks != '0)) begin
            state_next = sprm_pkg::ST_DIV;
          end else begin
            state_next = sprm_pkg::ST_HOLD;
          end
        end
      end
      sprm_pkg::ST_DIV: begin
        if (cnt == '0) begin
          state_next = sprm_pkg::ST_HOLD;
        end
      end
      sprm_pkg::ST_HOLD: begin
        if (ctrl.out_load) begin
          state_next = sprm_pkg::ST_IDLE;
        end
      end
      default: state_next = sprm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl.in_stall = 1'b1;
    ctrl.out_load = 1'b0;
    case (state)
      sprm_pkg::ST_IDLE: ctrl.in_stall = 1'b0;
      sprm_pkg::ST_DIV:  ctrl.in_stall = 1'b1;
      sprm_pkg::ST_HOLD: ctrl.out_load = !out_valid || !out_stall;
      default:           ctrl.in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sprm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rpm_numerator  <= sprm_pkg::NumReset;
      running_window <= sprm_pkg::WinReset;
    end else if (cfg_we) begin
      if (cfg_index == sprm_pkg::RegNumerator) begin
        rpm_numerator <= cfg_data[sprm_pkg::NumW-1:0];
      end else if (cfg_index == sprm_pkg::RegWindow) begin
        running_window <= cfg_data[sprm_pkg::WinW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed_ticks <= sprm_pkg::SatTicks;
      stored_rpm    <= '0;
    end else begin
      if (accept) begin
        if (kind == sprm_pkg::KindTick) begin
          if (elapsed_ticks != sprm_pkg::SatTicks) begin
            elapsed_ticks <= elapsed_ticks + 1'b1;
          end
        end else if (measured) begin
          if (is_running && (elapsed_ticks == '0)) begin
            stored_rpm <= sprm_pkg::RpmNoise;
          end
          elapsed_ticks <= '0;
        end
      end
      if ((state == sprm_pkg::ST_DIV) && (cnt == '0)) begin
        stored_rpm <= {1'b0, quo[sprm_pkg::NumW-2:0], q_bit};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == sprm_pkg::ST_IDLE) begin
      quo     <= rpm_numerator;
      rem     <= '0;
      divisor <= elapsed_ticks[sprm_pkg::WinW-1:0];
      cnt     <= sprm_pkg::CntW'(sprm_pkg::NumW - 1);
    end else if (state == sprm_pkg::ST_DIV) begin
      quo <= {quo[sprm_pkg::NumW-2:0], q_bit};
      rem <= rem_next;
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      rpm_value <= is_running ? stored_rpm : '0;
      running   <= is_running;
    end
  end

endmodule
